>>> hdl/ugt_pkg.sv
// Package for the unary graph table: operation codes, status codes and
// the sequencer state type. No dependencies.
`default_nettype none
package ugt_pkg;

	localparam logic [2:0] OP_ADD_VTX  = 3'd0;
	localparam logic [2:0] OP_ADD_EDGE = 3'd1;
	localparam logic [2:0] OP_DEL_VTX  = 3'd2;
	localparam logic [2:0] OP_CLR_IN   = 3'd3;
	localparam logic [2:0] OP_CLR_OUT  = 3'd4;
	localparam logic [2:0] OP_QUERY    = 3'd5;
	localparam logic [2:0] OP_PATH     = 3'd6;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_VTX  = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_NO_SUCC = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC,
		S_SWEEP,
		S_QRY1,
		S_QRY2,
		S_WALK_RD,
		S_WALK_CHK,
		S_DONE
	} ugt_state_t;

endpackage
`default_nettype wire

>>> hdl/ugt_mem.sv
// Simple dual-port synchronous memory: one write port, one read port,
// registered read data. No dependencies.
`default_nettype none
module ugt_mem #(
	parameter int DW    = 16,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> hdl/unary_graph_table_core.sv
// Unary graph table: vertex ids and edge targets live in two synchronous memories.
// Every word scans all MAX_VERTICES slots, then runs its operation in S_EXEC, plus a
// further sweep of all slots for delete and clear incoming, successor reads for query
// and a read-and-check walk for path. One word at a time, accepted in S_IDLE, its
// result loaded in S_DONE; a held result lets the next word run, but that word waits
// in S_DONE until the held one is taken. Async active-low reset empties the table.
`default_nettype none
module unary_graph_table_core #(
	parameter int MAX_VERTICES = 64,
	parameter int ID_BITS      = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  op,
	input  wire logic [15:0] vertex_a,
	input  wire logic [15:0] vertex_b,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             vertex_present,
	output logic [15:0]      successor_id,
	output logic             path_found,
	output logic [6:0]       vertex_total
);
	import ugt_pkg::*;

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int SB = (ID_BITS < 16) ? ID_BITS : 16;
	localparam logic [AW-1:0] LAST = AW'(MAX_VERTICES - 1);

	ugt_state_t state_q, state_d;

	logic [MAX_VERTICES-1:0] used_q, edge_q;
	logic [CW-1:0] count_q, steps_q;
	logic [2:0]    op_q;
	logic [SB-1:0] a_q, b_q;
	logic [AW-1:0] sa_q, sb_q, free_q, cnt_q, cur_q, idx_s1;
	logic          fa_q, fb_q, ffree_q, issue_q, vld_s1;
	logic [1:0]    rstat_q;
	logic          rmember_q, rpath_q;
	logic [SB-1:0] rsucc_q;

	logic          vtx_we, tgt_we;
	logic [AW-1:0] vtx_raddr, tgt_raddr;
	logic [SB-1:0] vtx_rdata;
	logic [AW-1:0] tgt_rdata;
	logic          sweep_end, accept, load_out;

	ugt_mem #(.DW(SB), .DEPTH(MAX_VERTICES)) u_vtx (
		.clk(clk), .we(vtx_we), .waddr(free_q), .wdata(a_q),
		.raddr(vtx_raddr), .rdata(vtx_rdata)
	);

	ugt_mem #(.DW(AW), .DEPTH(MAX_VERTICES)) u_tgt (
		.clk(clk), .we(tgt_we), .waddr(sa_q), .wdata(sb_q),
		.raddr(tgt_raddr), .rdata(tgt_rdata)
	);

	assign sweep_end = vld_s1 && (idx_s1 == LAST);
	assign accept    = in_valid && in_ready;
	assign load_out  = (state_q == S_DONE) && (!out_valid || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sweep_end) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (op_q)
					OP_DEL_VTX, OP_CLR_IN: state_d = fa_q ? S_SWEEP : S_DONE;
					OP_QUERY:              state_d = fa_q ? S_QRY1 : S_DONE;
					OP_PATH:               state_d = (fa_q && fb_q && sa_q != sb_q) ?
					                                 S_WALK_RD : S_DONE;
					default:               state_d = S_DONE;
				endcase
			end
			S_SWEEP: begin
				if (sweep_end) state_d = S_DONE;
			end
			S_QRY1: begin
				state_d = (edge_q[sa_q] && used_q[tgt_rdata]) ? S_QRY2 : S_DONE;
			end
			S_QRY2: state_d = S_DONE;
			S_WALK_RD: begin
				state_d = (steps_q == '0 || !edge_q[cur_q]) ? S_DONE : S_WALK_CHK;
			end
			S_WALK_CHK: begin
				state_d = (!used_q[tgt_rdata] || tgt_rdata == sb_q) ? S_DONE : S_WALK_RD;
			end
			S_DONE: begin
				if (load_out) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == S_IDLE);
		vtx_raddr = (state_q == S_QRY1) ? tgt_rdata : cnt_q;
		case (state_q)
			S_EXEC:    tgt_raddr = sa_q;
			S_WALK_RD: tgt_raddr = cur_q;
			default:   tgt_raddr = cnt_q;
		endcase
		vtx_we = (state_q == S_EXEC) && (op_q == OP_ADD_VTX) && !fa_q && ffree_q;
		tgt_we = (state_q == S_EXEC) && (op_q == OP_ADD_EDGE) && fa_q && fb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			edge_q    <= '0;
			count_q   <= '0;
			issue_q   <= 1'b0;
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == S_SCAN || state_q == S_SWEEP) && issue_q;
			if (load_out) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (accept || (state_q == S_EXEC && state_d == S_SWEEP)) issue_q <= 1'b1;
			else if ((state_q == S_SCAN || state_q == S_SWEEP) && issue_q && cnt_q == LAST)
				issue_q <= 1'b0;
			case (state_q)
				S_EXEC: begin
					case (op_q)
						OP_ADD_VTX: begin
							if (vtx_we) begin
								used_q[free_q] <= 1'b1;
								edge_q[free_q] <= 1'b0;
								count_q        <= count_q + 1'b1;
							end
						end
						OP_ADD_EDGE: begin
							if (tgt_we) edge_q[sa_q] <= 1'b1;
						end
						OP_DEL_VTX: begin
							if (fa_q) begin
								used_q[sa_q] <= 1'b0;
								edge_q[sa_q] <= 1'b0;
								if (count_q != '0) count_q <= count_q - 1'b1;
							end
						end
						OP_CLR_OUT: begin
							if (fa_q) edge_q[sa_q] <= 1'b0;
						end
						default: ;
					endcase
				end
				S_SWEEP: begin
					if (vld_s1 && used_q[idx_s1] && edge_q[idx_s1] && tgt_rdata == sa_q)
						edge_q[idx_s1] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if ((state_q == S_SCAN || state_q == S_SWEEP) && issue_q && cnt_q != LAST)
			cnt_q <= cnt_q + 1'b1;
		if (accept) begin
			op_q      <= op;
			a_q       <= vertex_a[SB-1:0];
			b_q       <= vertex_b[SB-1:0];
			fa_q      <= 1'b0;
			fb_q      <= 1'b0;
			ffree_q   <= 1'b0;
			cnt_q     <= '0;
			rstat_q   <= ST_OK;
			rmember_q <= 1'b0;
			rpath_q   <= 1'b0;
			rsucc_q   <= '0;
		end
		case (state_q)
			S_SCAN: begin
				if (vld_s1) begin
					if (used_q[idx_s1] && vtx_rdata == a_q) begin
						fa_q <= 1'b1;
						sa_q <= idx_s1;
					end
					if (used_q[idx_s1] && vtx_rdata == b_q) begin
						fb_q <= 1'b1;
						sb_q <= idx_s1;
					end
					if (!used_q[idx_s1] && !ffree_q) begin
						ffree_q <= 1'b1;
						free_q  <= idx_s1;
					end
				end
			end
			S_EXEC: begin
				cnt_q   <= '0;
				cur_q   <= sa_q;
				steps_q <= count_q - 1'b1;
				case (op_q)
					OP_ADD_VTX: begin
						if (!fa_q && !ffree_q) rstat_q <= ST_FULL;
					end
					OP_ADD_EDGE, OP_PATH: begin
						if (!fa_q || !fb_q) rstat_q <= ST_NO_VTX;
						else if (op_q == OP_PATH && sa_q == sb_q) rpath_q <= 1'b1;
					end
					OP_DEL_VTX, OP_CLR_IN, OP_CLR_OUT: begin
						if (!fa_q) rstat_q <= ST_NO_VTX;
					end
					OP_QUERY: begin
						if (!fa_q) rstat_q <= ST_NO_VTX;
						else rmember_q <= 1'b1;
					end
					default: ;
				endcase
			end
			S_QRY1: begin
				if (!(edge_q[sa_q] && used_q[tgt_rdata])) rstat_q <= ST_NO_SUCC;
			end
			S_QRY2: rsucc_q <= vtx_rdata;
			S_WALK_CHK: begin
				cur_q   <= tgt_rdata;
				steps_q <= steps_q - 1'b1;
				if (used_q[tgt_rdata] && tgt_rdata == sb_q) rpath_q <= 1'b1;
			end
			S_DONE: begin
				if (load_out) begin
					status         <= rstat_q;
					vertex_present <= rmember_q;
					successor_id   <= 16'(rsucc_q);
					path_found     <= rpath_q;
					vertex_total   <= 7'(count_q);
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> tb/unary_graph_table_core_tb.sv
// Self-checking bench for unary_graph_table_core: a directed table, then random
// words, all checked against a behavioural table model. Depends on ugt_pkg and unary_graph_table_core.
`timescale 1ns / 1ps
`default_nettype none
module unary_graph_table_core_tb;
	import ugt_pkg::*;

	localparam int NV = 64;
	localparam logic [2:0] OP_SPARE = 3'd7;

	typedef struct packed {
		logic [1:0]  status;
		logic        vertex_present;
		logic [15:0] successor_id;
		logic        path_found;
		logic [6:0]  vertex_total;
	} answer_t;

	typedef struct {
		logic [2:0]  op;
		logic [15:0] va;
		logic [15:0] vb;
		logic        typed;
		answer_t     ans;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] op = '0;
	logic [15:0] vertex_a = '0;
	logic [15:0] vertex_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic vertex_present;
	logic [15:0] successor_id;
	logic path_found;
	logic [6:0] vertex_total;

	bit used [NV];
	logic [15:0] ids [NV];
	bit linked [NV];
	int unsigned target [NV];
	int unsigned count;

	answer_t answers_due [$];
	int errors = 0;
	int send_gap = 0;
	int recv_stall = 0;

	always #4 clk = ~clk;

	unary_graph_table_core dut (.*);

	function automatic int slot_of(logic [15:0] id);
		for (int i = 0; i < NV; i++)
			if (used[i] && ids[i] == id) return i;
		return NV;
	endfunction

	function automatic bit walk_reaches(int sa, int sb);
		int cur;
		int steps;
		cur = sa;
		if (sa == sb) return 1;
		steps = count > 0 ? count - 1 : 0;
		while (steps != 0) begin
			if (!linked[cur]) return 0;
			cur = target[cur];
			if (!used[cur]) return 0;
			if (cur == sb) return 1;
			steps--;
		end
		return 0;
	endfunction

	function automatic void drop_incoming(int s);
		for (int i = 0; i < NV; i++)
			if (used[i] && linked[i] && target[i] == s) linked[i] = 0;
	endfunction

	function automatic answer_t table_apply(logic [2:0] o, logic [15:0] a, logic [15:0] b);
		answer_t r;
		int sa;
		int sb;
		int f;
		r = '0;
		sa = slot_of(a);
		sb = slot_of(b);
		case (o)
			OP_ADD_VTX: if (sa == NV) begin
				f = NV;
				for (int i = NV - 1; i >= 0; i--) if (!used[i]) f = i;
				if (f == NV) r.status = ST_FULL;
				else begin
					used[f] = 1; ids[f] = a; linked[f] = 0; target[f] = 0; count++;
				end
			end
			OP_ADD_EDGE: if (sa == NV || sb == NV) r.status = ST_NO_VTX;
				else begin linked[sa] = 1; target[sa] = sb; end
			OP_DEL_VTX: if (sa == NV) r.status = ST_NO_VTX;
				else begin
					drop_incoming(sa); used[sa] = 0; linked[sa] = 0;
					if (count > 0) count--;
				end
			OP_CLR_IN: if (sa == NV) r.status = ST_NO_VTX; else drop_incoming(sa);
			OP_CLR_OUT: if (sa == NV) r.status = ST_NO_VTX; else linked[sa] = 0;
			OP_QUERY: if (sa == NV) r.status = ST_NO_VTX;
				else begin
					r.vertex_present = 1;
					if (linked[sa] && used[target[sa]]) r.successor_id = ids[target[sa]];
					else r.status = ST_NO_SUCC;
				end
			OP_PATH: if (sa == NV || sb == NV) r.status = ST_NO_VTX;
				else r.path_found = walk_reaches(sa, sb);
			default: ;
		endcase
		r.vertex_total = count[6:0];
		return r;
	endfunction

	task automatic send_word(logic [2:0] o, logic [15:0] a, logic [15:0] b, bit typed,
			answer_t want);
		answer_t p;
		while (send_gap > 0 && $urandom_range(99) < send_gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		p = table_apply(o, a, b);
		if (typed && p != want) begin
			$error("typed row disagrees: op=%0d want=%h model=%h", o, want, p);
			errors++;
		end
		answers_due.push_back(typed ? want : p);
		in_valid <= 1'b1;
		op <= o;
		vertex_a <= a;
		vertex_b <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_id(bit wide);
		return wide ? 16'($urandom) : 16'($urandom_range(23) ^ ($urandom_range(1) ? 16'hA5C0 : 0));
	endfunction

	always @(posedge clk) begin
		answer_t w;
		if (out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				$error("unexpected word status=%0d", status);
				errors++;
			end else begin
				w = answers_due.pop_front();
				if (status !== w.status) begin
					$error("status exp %0d got %0d", w.status, status); errors++; end
				if (vertex_present !== w.vertex_present) begin
					$error("vertex_present exp %0d got %0d", w.vertex_present,
						vertex_present);
					errors++;
				end
				if (successor_id !== w.successor_id) begin
					$error("successor_id exp %h got %h", w.successor_id, successor_id);
					errors++;
				end
				if (path_found !== w.path_found) begin
					$error("path_found exp %0d got %0d", w.path_found, path_found); errors++; end
				if (vertex_total !== w.vertex_total) begin
					$error("vertex_total exp %0d got %0d", w.vertex_total, vertex_total);
					errors++;
				end
			end
		end
		out_ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
	end

	initial begin
		#30ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		row_t rows [$];
		row_t r;
		logic [2:0] o;
		logic [15:0] a;
		logic [15:0] b;
		int k;
		rows = '{
			'{OP_QUERY,    16'h0000, 16'h0000, 1, '{ST_NO_VTX, 0, 0, 0, 0}},
			'{OP_ADD_VTX,  16'h0000, 16'h0000, 1, '{ST_OK, 0, 0, 0, 1}},
			'{OP_ADD_VTX,  16'hFFFF, 16'h0000, 1, '{ST_OK, 0, 0, 0, 2}},
			'{OP_ADD_VTX,  16'hFFFF, 16'h0000, 1, '{ST_OK, 0, 0, 0, 2}},
			'{OP_QUERY,    16'h0000, 16'h0000, 1, '{ST_NO_SUCC, 1, 0, 0, 2}},
			'{OP_ADD_EDGE, 16'h0000, 16'hFFFF, 1, '{ST_OK, 0, 0, 0, 2}},
			'{OP_ADD_EDGE, 16'h0000, 16'h1234, 1, '{ST_NO_VTX, 0, 0, 0, 2}},
			'{OP_QUERY,    16'h0000, 16'h0000, 1, '{ST_OK, 1, 16'hFFFF, 0, 2}},
			'{OP_PATH,     16'h0000, 16'hFFFF, 1, '{ST_OK, 0, 0, 1, 2}},
			'{OP_PATH,     16'hFFFF, 16'h0000, 1, '{ST_OK, 0, 0, 0, 2}},
			'{OP_PATH,     16'hFFFF, 16'hFFFF, 1, '{ST_OK, 0, 0, 1, 2}},
			'{OP_PATH,     16'h0000, 16'h5555, 1, '{ST_NO_VTX, 0, 0, 0, 2}},
			'{OP_ADD_EDGE, 16'hFFFF, 16'h0000, 0, '0},
			'{OP_CLR_IN,   16'hFFFF, 16'h0000, 0, '0},
			'{OP_QUERY,    16'h0000, 16'h0000, 1, '{ST_NO_SUCC, 1, 0, 0, 2}},
			'{OP_CLR_OUT,  16'hFFFF, 16'h0000, 0, '0},
			'{OP_CLR_OUT,  16'h7777, 16'h0000, 1, '{ST_NO_VTX, 0, 0, 0, 2}},
			'{OP_CLR_IN,   16'h7777, 16'h0000, 1, '{ST_NO_VTX, 0, 0, 0, 2}},
			'{OP_ADD_EDGE, 16'hFFFF, 16'h0000, 0, '0},
			'{OP_DEL_VTX,  16'h0000, 16'h0000, 1, '{ST_OK, 0, 0, 0, 1}},
			'{OP_QUERY,    16'hFFFF, 16'h0000, 1, '{ST_NO_SUCC, 1, 0, 0, 1}},
			'{OP_DEL_VTX,  16'h0000, 16'h0000, 1, '{ST_NO_VTX, 0, 0, 0, 1}},
			'{OP_ADD_VTX,  16'h0000, 16'h0000, 1, '{ST_OK, 0, 0, 0, 2}},
			'{OP_SPARE,    16'hFFFF, 16'hFFFF, 1, '{ST_OK, 0, 0, 0, 2}}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			r = rows[i];
			send_word(r.op, r.va, r.vb, r.typed, r.ans);
		end
		for (int ph = 0; ph < 3; ph++) begin
			send_gap = ph == 0 ? 36 : 0;
			recv_stall = ph == 0 ? 79 : (ph == 1 ? 36 : 0);
			if (ph == 1) send_gap = 79;
			for (int n = 0; n < 250; n++) begin
				if (n == 120) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (answers_due.size() != 0) @(posedge clk);
				end
				k = $urandom_range(99);
				a = pick_id(k < 4);
				b = pick_id(k > 95);
				if (ph == 2 && n < 80) o = OP_ADD_VTX;
				else if (k < 28) o = OP_ADD_VTX;
				else if (k < 48) o = OP_ADD_EDGE;
				else if (k < 56) o = OP_DEL_VTX;
				else if (k < 61) o = OP_CLR_IN;
				else if (k < 65) o = OP_CLR_OUT;
				else if (k < 78) o = OP_QUERY;
				else if (k < 98) o = OP_PATH;
				else o = OP_SPARE;
				if (ph == 2 && n < 80) a = 16'($urandom);
				send_word(o, a, b, 0, '0);
			end
		end
		in_valid <= 1'b0;
		send_gap = 0;
		recv_stall = 0;
		k = 0;
		while (answers_due.size() != 0 && k < 200000) begin
			@(posedge clk);
			k++;
		end
		repeat (300) @(posedge clk);
		if (errors == 0 && answers_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
hdl/ugt_pkg.sv
hdl/ugt_mem.sv
hdl/unary_graph_table_core.sv
tb/unary_graph_table_core_tb.sv
